### hw/rtl/electronic_gear_step_generator_assert.svh
// Assertion macros for the electronic gear step generator.
// Needs a clock and an active-low synchronous reset named at each use.
`ifndef ELECTRONIC_GEAR_STEP_GENERATOR_ASSERT_SVH
`define ELECTRONIC_GEAR_STEP_GENERATOR_ASSERT_SVH

// Antecedent true implies consequent in the same cycle.
`define EGSG_ASSERT_SAME(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("egsg assertion failed");

// Antecedent true implies consequent in the following cycle.
`define EGSG_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("egsg assertion failed");

`endif

### hw/rtl/egsg_pkg.sv
// Shared constants for the electronic gear step generator.
// No dependencies; used by electronic_gear_step_generator.
package egsg_pkg;

  localparam int COUNTS_PER_REV = 2400;
  localparam int FRAC_BITS      = 16;

  localparam int ENC_W  = 32;
  localparam int POS_W  = 32;
  localparam int SPC_W  = 24;
  localparam int CPS_W  = 16;
  localparam int WIN_W  = 16;
  localparam int BL_W   = 8;
  localparam int THR_W  = 16;

  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  localparam int IN_TDATA_W  = 40;
  localparam int OUT_FIELDS_W = 1 + 1 + BL_W + 1 + 1 + POS_W;
  localparam int OUT_TDATA_W = 48;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_STEPS_PER_COUNT = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_CPS_INT         = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_CPS_FRAC        = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SYNC_WINDOW     = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_BACKLASH        = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_TARGET_POS      = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_TARGET_EN       = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_TARGET_THR      = 3'd7;

  // Angle within a revolution: remainder by reciprocal multiplication.
  localparam int CPR_LOG2    = $clog2(COUNTS_PER_REV);
  localparam int REM_W       = CPR_LOG2 + 1;
  localparam int RECIP_SHIFT = 31 + CPR_LOG2;
  localparam logic [63:0] RECIP_FULL = (64'd1 << RECIP_SHIFT) / 64'(COUNTS_PER_REV);
  localparam logic [31:0] RECIP      = RECIP_FULL[31:0];
  localparam logic [63:0] WRAP_REM_FULL = (64'd1 << 32) % 64'(COUNTS_PER_REV);
  localparam logic [REM_W-1:0] WRAP_REM = WRAP_REM_FULL[REM_W-1:0];
  localparam logic [REM_W-1:0] CPR_R    = REM_W'(COUNTS_PER_REV);
  localparam logic [ENC_W-1:0] CPR_ENC  = ENC_W'(COUNTS_PER_REV);

endpackage

### hw/rtl/electronic_gear_step_generator.sv
// Electronic gear step generator: accepts one input beat per cycle unless the output
// stalls on out_tready. Three stages find the spindle angle
// (reciprocal multiply, remainder fix, sign fold); the gearing stage then does one
// 32x24 multiply and updates the gear state in the cycle the result is registered.
// Reset (rst_n low, synchronous) clears config registers, gear state, valid flags.
// Depends on egsg_pkg and electronic_gear_step_generator_assert.svh.
`include "electronic_gear_step_generator_assert.svh"

module electronic_gear_step_generator (
  input  logic                                  clk,
  input  logic                                  rst_n,
  input  logic                                  in_tvalid,
  output logic                                  in_tready,
  // [31:0] encoder_count, [32] spindle_enabled, [39:33] zero
  input  logic [egsg_pkg::IN_TDATA_W-1:0]       in_tdata,
  output logic                                  out_tvalid,
  input  logic                                  out_tready,
  // [0] step_pulse, [1] step_direction, [9:2] backlash_pulses, [10] stop_request,
  // [11] in_sync, [43:12] position, [47:44] zero
  output logic [egsg_pkg::OUT_TDATA_W-1:0]      out_tdata,
  input  logic                                  cfg_wr_en,
  input  logic [egsg_pkg::CFG_IDX_W-1:0]        cfg_index,
  input  logic [egsg_pkg::CFG_DATA_W-1:0]       cfg_wdata
);

  localparam int EW   = egsg_pkg::ENC_W;
  localparam int PW   = egsg_pkg::POS_W;
  localparam int RW   = egsg_pkg::REM_W;
  localparam int FB   = egsg_pkg::FRAC_BITS;
  localparam int PRODW = EW + egsg_pkg::SPC_W;

  // Configuration registers.
  logic [egsg_pkg::SPC_W-1:0] spc_r;
  logic [egsg_pkg::CPS_W-1:0] cps_int_r;
  logic [egsg_pkg::CPS_W-1:0] cps_frac_r;
  logic [egsg_pkg::WIN_W-1:0] window_r;
  logic [egsg_pkg::BL_W-1:0]  backlash_r;
  logic [PW-1:0]              target_r;
  logic                       target_en_r;
  logic [egsg_pkg::THR_W-1:0] threshold_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      spc_r       <= '0;
      cps_int_r   <= '0;
      cps_frac_r  <= '0;
      window_r    <= '0;
      backlash_r  <= '0;
      target_r    <= '0;
      target_en_r <= 1'b0;
      threshold_r <= '0;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        egsg_pkg::REG_STEPS_PER_COUNT: spc_r       <= cfg_wdata[egsg_pkg::SPC_W-1:0];
        egsg_pkg::REG_CPS_INT:         cps_int_r   <= cfg_wdata[egsg_pkg::CPS_W-1:0];
        egsg_pkg::REG_CPS_FRAC:        cps_frac_r  <= cfg_wdata[egsg_pkg::CPS_W-1:0];
        egsg_pkg::REG_SYNC_WINDOW:     window_r    <= cfg_wdata[egsg_pkg::WIN_W-1:0];
        egsg_pkg::REG_BACKLASH:        backlash_r  <= cfg_wdata[egsg_pkg::BL_W-1:0];
        egsg_pkg::REG_TARGET_POS:      target_r    <= cfg_wdata[PW-1:0];
        egsg_pkg::REG_TARGET_EN:       target_en_r <= cfg_wdata[0];
        egsg_pkg::REG_TARGET_THR:      threshold_r <= cfg_wdata[egsg_pkg::THR_W-1:0];
        default: ;
      endcase
    end
  end

  // Pipeline flow control: a stage loads when it is empty or its successor loads.
  logic s1_v_r, s2_v_r, s3_v_r, out_v_r;
  logic free_out, ld3, ld2, ld1, fire;

  assign free_out  = !out_v_r || out_tready;
  assign ld3       = !s3_v_r || free_out;
  assign ld2       = !s2_v_r || ld3;
  assign ld1       = !s1_v_r || ld2;
  assign fire      = s3_v_r && free_out;
  assign in_tready = ld1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r  <= 1'b0;
      s2_v_r  <= 1'b0;
      s3_v_r  <= 1'b0;
      out_v_r <= 1'b0;
    end else begin
      if (ld1)      s1_v_r  <= in_tvalid;
      if (ld2)      s2_v_r  <= s1_v_r;
      if (ld3)      s3_v_r  <= s2_v_r;
      if (free_out) out_v_r <= s3_v_r;
    end
  end

  // Stage 1: quotient estimate by the reciprocal, at most one low.
  logic [EW-1:0] s1_enc_r;
  logic          s1_en_r;
  logic [EW-1:0] s1_q_r;
  logic [63:0]   recip_prod;

  assign recip_prod = {32'd0, in_tdata[EW-1:0]} * {32'd0, egsg_pkg::RECIP};

  // Stage 2: remainder of the unsigned count, corrected into [0, COUNTS_PER_REV).
  logic [EW-1:0] s2_enc_r;
  logic          s2_en_r;
  logic [RW-1:0] s2_rem_r;
  logic [EW-1:0] qc;
  logic [EW-1:0] rem_full;
  logic [RW-1:0] rem_raw;
  logic [RW-1:0] rem_fix;

  assign qc       = EW'(s1_q_r * egsg_pkg::CPR_ENC);
  assign rem_full = s1_enc_r - qc;
  assign rem_raw  = rem_full[RW-1:0];
  assign rem_fix  = (rem_raw >= egsg_pkg::CPR_R) ? rem_raw - egsg_pkg::CPR_R : rem_raw;

  // Stage 3: a negative count shifts the remainder by 2^32 mod COUNTS_PER_REV.
  logic [EW-1:0] s3_enc_r;
  logic          s3_en_r;
  logic [RW-1:0] s3_ang_r;
  logic [RW-1:0] ang_nxt;

  always_comb begin
    ang_nxt = s2_rem_r;
    if (s2_enc_r[EW-1]) begin
      if (s2_rem_r >= egsg_pkg::WRAP_REM) begin
        ang_nxt = s2_rem_r - egsg_pkg::WRAP_REM;
      end else begin
        ang_nxt = s2_rem_r + egsg_pkg::CPR_R - egsg_pkg::WRAP_REM;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ld1) begin
      s1_enc_r <= in_tdata[EW-1:0];
      s1_en_r  <= in_tdata[EW];
      s1_q_r   <= EW'(recip_prod >> egsg_pkg::RECIP_SHIFT);
    end
    if (ld2) begin
      s2_enc_r <= s1_enc_r;
      s2_en_r  <= s1_en_r;
      s2_rem_r <= rem_fix;
    end
    if (ld3) begin
      s3_enc_r <= s2_enc_r;
      s3_en_r  <= s2_en_r;
      s3_ang_r <= ang_nxt;
    end
  end

  // Gear state.
  logic [EW-1:0] ref_r, ref_nxt;
  logic [FB-1:0] acc_r, acc_nxt;
  logic [PW-1:0] pos_r, pos_nxt;
  logic          last_dir_r, last_dir_nxt;
  logic          dir_chg_r, dir_chg_nxt;
  logic          synced_r, synced_nxt;

  logic [EW-1:0]   diff;
  logic [EW-1:0]   mag;
  logic [PRODW-1:0] gear_prod;
  logic            due;
  logic            dir_due;
  logic            ang_ok;
  logic [PW:0]     tgt_diff;
  logic [PW:0]     tgt_mag;
  logic            near;
  logic [FB:0]     frac_sum;
  logic [EW-1:0]   amount;
  logic            go;
  logic            pulse, dir_o, stop;
  logic [egsg_pkg::BL_W-1:0] bl_o;

  assign diff      = s3_enc_r - ref_r;
  assign mag       = diff[EW-1] ? (EW'(0) - diff) : diff;
  assign gear_prod = PRODW'(mag) * PRODW'(spc_r);
  assign due       = |gear_prod[PRODW-1:FB];
  assign dir_due   = !diff[EW-1];
  assign ang_ok    = 32'(s3_ang_r) <= 32'(window_r);
  assign tgt_diff  = {target_r[PW-1], target_r} - {pos_r[PW-1], pos_r};
  assign tgt_mag   = tgt_diff[PW] ? ((PW+1)'(0) - tgt_diff) : tgt_diff;
  assign near      = tgt_mag <= (PW+1)'(threshold_r);
  assign frac_sum  = {1'b0, acc_r} + {1'b0, FB'(cps_frac_r)};
  assign amount    = EW'(cps_int_r) + EW'(frac_sum[FB]);

  always_comb begin
    ref_nxt      = ref_r;
    acc_nxt      = acc_r;
    pos_nxt      = pos_r;
    last_dir_nxt = last_dir_r;
    dir_chg_nxt  = dir_chg_r;
    synced_nxt   = synced_r;
    pulse        = 1'b0;
    stop         = 1'b0;
    bl_o         = '0;
    go           = 1'b0;
    dir_o        = due ? dir_due : last_dir_r;
    if (due) begin
      if (!s3_en_r) begin
        ref_nxt = s3_enc_r;
      end else begin
        go = 1'b1;
        if (last_dir_r != dir_due) begin
          last_dir_nxt = dir_due;
          dir_chg_nxt  = 1'b1;
          bl_o         = backlash_r;
        end
        if (!synced_r) begin
          if (ang_ok) begin
            synced_nxt = 1'b1;
          end else begin
            ref_nxt = s3_enc_r;
            go      = 1'b0;
          end
        end
        // The first step after a reversal is never held at the target.
        if (go && target_en_r && !dir_chg_nxt && near) begin
          stop = 1'b1;
          go   = 1'b0;
        end
        if (go) begin
          pos_nxt     = dir_due ? pos_r + PW'(1) : pos_r - PW'(1);
          acc_nxt     = frac_sum[FB-1:0];
          ref_nxt     = dir_due ? ref_r + amount : ref_r - amount;
          dir_chg_nxt = 1'b0;
          pulse       = 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ref_r      <= '0;
      acc_r      <= '0;
      pos_r      <= '0;
      last_dir_r <= 1'b0;
      dir_chg_r  <= 1'b0;
      synced_r   <= 1'b0;
    end else if (fire) begin
      ref_r      <= ref_nxt;
      acc_r      <= acc_nxt;
      pos_r      <= pos_nxt;
      last_dir_r <= last_dir_nxt;
      dir_chg_r  <= dir_chg_nxt;
      synced_r   <= synced_nxt;
    end
  end

  // Result register.
  logic [egsg_pkg::OUT_TDATA_W-1:0] out_tdata_r;

  always_ff @(posedge clk) begin
    if (free_out) begin
      out_tdata_r <= {(egsg_pkg::OUT_TDATA_W - egsg_pkg::OUT_FIELDS_W)'(0),
                      pos_nxt, synced_nxt, stop, bl_o, dir_o, pulse};
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = out_tdata_r;

  `EGSG_ASSERT_SAME(a_pulse_not_stopped, clk, rst_n, out_v_r && out_tdata_r[0], !out_tdata_r[10])
  `EGSG_ASSERT_SAME(a_pulse_needs_sync, clk, rst_n, out_v_r && out_tdata_r[0], out_tdata_r[11])
  `EGSG_ASSERT_NEXT(a_sync_sticks, clk, rst_n, synced_r, synced_r)
  `EGSG_ASSERT_NEXT(a_state_holds_idle, clk, rst_n, !fire, $stable(pos_r) && $stable(ref_r))

endmodule

### tb/testbench.sv
// Self-checking testbench for the electronic gear step generator.
// Holds its own gearing predictor and drives the stream and config ports.
// Depends on egsg_pkg and electronic_gear_step_generator from hw/rtl.
`timescale 1ns / 100ps

module testbench;
  import egsg_pkg::*;

  typedef struct packed {
    logic        pulse;
    logic        dir;
    logic [7:0]  backlash;
    logic        stop;
    logic        sync;
    logic [31:0] pos;
  } gear_result_t;

  logic                   clk = 1'b0;
  logic                   rst_n = 1'b0;
  logic                   in_tvalid = 1'b0;
  logic                   in_tready;
  logic [IN_TDATA_W-1:0]  in_tdata = '0;
  logic                   out_tvalid;
  logic                   out_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] out_tdata;
  logic                   cfg_wr_en = 1'b0;
  logic [CFG_IDX_W-1:0]   cfg_index = '0;
  logic [CFG_DATA_W-1:0]  cfg_wdata = '0;

  // Predictor copy of the registers.
  logic [23:0] m_spc = '0;
  logic [15:0] m_cps_int = '0;
  logic [15:0] m_cps_frac = '0;
  logic [15:0] m_window = '0;
  logic [7:0]  m_backlash = '0;
  logic [31:0] m_target = '0;
  logic        m_target_en = 1'b0;
  logic [15:0] m_threshold = '0;

  // Predictor copy of the gear state.
  logic [31:0] ref_count = '0;
  logic [15:0] frac_acc = '0;
  logic [31:0] stepper_pos = '0;
  logic        last_dir = 1'b0;
  logic        dir_changed = 1'b0;
  logic        synced = 1'b0;

  gear_result_t expected_steps[$];
  int          mismatches = 0;
  logic [31:0] enc_now = '0;
  logic        no_idle = 1'b0;

  electronic_gear_step_generator u_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  initial begin
    #4000000;
    $display("end of test: mismatches");
    $finish;
  end

  function automatic gear_result_t predict_gear(logic [31:0] enc, logic en);
    logic [31:0]  diff;
    longint       sd, mag, prod, ang, tgt_dist;
    logic         dirn, go;
    logic [16:0]  fsum;
    logic [31:0]  amount;
    gear_result_t r;
    diff = enc - ref_count;
    sd = longint'($signed(diff));
    mag = (sd < 0) ? -sd : sd;
    prod = mag * longint'(m_spc);
    r = '0;
    r.dir = last_dir;
    if (prod >= (longint'(1) << FRAC_BITS)) begin
      dirn = (sd > 0);
      r.dir = dirn;
      if (!en) begin
        ref_count = enc;
      end else begin
        go = 1'b1;
        if (last_dir != dirn) begin
          last_dir = dirn;
          dir_changed = 1'b1;
          r.backlash = m_backlash;
        end
        if (!synced) begin
          ang = longint'($signed(enc)) % COUNTS_PER_REV;
          if (ang < 0) ang = ang + COUNTS_PER_REV;
          if (ang <= longint'(m_window)) begin
            synced = 1'b1;
          end else begin
            ref_count = enc;
            go = 1'b0;
          end
        end
        if (go && m_target_en && !dir_changed) begin
          tgt_dist = longint'($signed(m_target)) - longint'($signed(stepper_pos));
          if (tgt_dist < 0) tgt_dist = -tgt_dist;
          if (tgt_dist <= longint'(m_threshold)) begin
            r.stop = 1'b1;
            go = 1'b0;
          end
        end
        if (go) begin
          stepper_pos = dirn ? stepper_pos + 32'd1 : stepper_pos - 32'd1;
          // The fraction always accumulates upward; the carry joins the integer part.
          fsum = {1'b0, frac_acc} + {1'b0, m_cps_frac};
          amount = {16'd0, m_cps_int} + {31'd0, fsum[16]};
          frac_acc = fsum[15:0];
          ref_count = dirn ? ref_count + amount : ref_count - amount;
          dir_changed = 1'b0;
          r.pulse = 1'b1;
        end
      end
    end
    r.sync = synced;
    r.pos = stepper_pos;
    return r;
  endfunction

  function automatic int pick_gap();
    int r;
    if (no_idle) return 0;
    r = $urandom_range(0, 99);
    if (r < 65) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(8, 40);
  endfunction

  // Result side: random stalls, with ready held high between them.
  initial begin : ready_gen
    int n;
    forever begin
      n = pick_gap();
      if (n > 0) begin
        out_tready <= 1'b0;
        repeat (n) @(posedge clk);
      end
      out_tready <= 1'b1;
      repeat ($urandom_range(1, 20)) @(posedge clk);
    end
  end

  always @(posedge clk) begin
    gear_result_t got, want;
    if (rst_n && out_tvalid && out_tready) begin
      got.pulse    = out_tdata[0];
      got.dir      = out_tdata[1];
      got.backlash = out_tdata[9:2];
      got.stop     = out_tdata[10];
      got.sync     = out_tdata[11];
      got.pos      = out_tdata[43:12];
      if (expected_steps.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("%0t: result beat with nothing expected: %h", $realtime, out_tdata);
      end else begin
        want = expected_steps.pop_front();
        if (got.pulse !== want.pulse || got.dir !== want.dir ||
            got.backlash !== want.backlash || got.stop !== want.stop ||
            got.sync !== want.sync || got.pos !== want.pos) begin
          mismatches++;
          if (mismatches <= 10)
            $display("%0t: expected pulse=%b dir=%b bl=%0d stop=%b sync=%b pos=%h, got %b %b %0d %b %b %h",
                     $realtime, want.pulse, want.dir, want.backlash, want.stop, want.sync,
                     want.pos, got.pulse, got.dir, got.backlash, got.stop, got.sync,
                     got.pos);
        end
      end
    end
  end

  task automatic send_sample(input logic [31:0] enc, input logic en);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {{(IN_TDATA_W-33){1'b0}}, en, enc};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    expected_steps.push_back(predict_gear(enc, en));
    enc_now = enc;
  endtask

  task automatic wait_idle();
    in_tvalid <= 1'b0;
    while (expected_steps.size() != 0) @(posedge clk);
    repeat (6) @(posedge clk);
  endtask

  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [31:0] val);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    case (idx)
      REG_STEPS_PER_COUNT: m_spc = val[23:0];
      REG_CPS_INT:         m_cps_int = val[15:0];
      REG_CPS_FRAC:        m_cps_frac = val[15:0];
      REG_SYNC_WINDOW:     m_window = val[15:0];
      REG_BACKLASH:        m_backlash = val[7:0];
      REG_TARGET_POS:      m_target = val;
      REG_TARGET_EN:       m_target_en = val[0];
      REG_TARGET_THR:      m_threshold = val[15:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  task automatic load_gear_setup(input logic [31:0] spc, cps_int, cps_frac, window,
                                 backlash, target, tgt_en, thr);
    write_reg(REG_STEPS_PER_COUNT, spc);
    write_reg(REG_CPS_INT, cps_int);
    write_reg(REG_CPS_FRAC, cps_frac);
    write_reg(REG_SYNC_WINDOW, window);
    write_reg(REG_BACKLASH, backlash);
    write_reg(REG_TARGET_POS, target);
    write_reg(REG_TARGET_EN, tgt_en);
    write_reg(REG_TARGET_THR, thr);
    cfg_wr_en <= 1'b0;
  endtask

  // With the spindle off a due step only drags the reference along.
  task automatic test_spindle_off();
    load_gear_setup(32'h10000, 1, 0, 0, 255, 0, 0, 0);
    send_sample(32'h0000_0000, 1'b0);
    send_sample(32'h7FFF_FFFF, 1'b0);
    send_sample(32'h8000_0000, 1'b0);
    send_sample(32'h8000_0000, 1'b0);
  endtask

  // Window of zero: only an angle of exactly zero takes the sync.
  task automatic test_sync_window();
    send_sample(32'd2401, 1'b1);
    send_sample(32'd2405, 1'b1);
    send_sample(-32'sd5, 1'b1);
    send_sample(-32'sd2400, 1'b1);
  endtask

  task automatic test_backward_carry();
    int k;
    wait_idle();
    load_gear_setup(32'h8000, 2, 32'hC000, 0, 3, 0, 0, 0);
    for (k = 0; k < 4; k++) send_sample(enc_now - 32'd3, 1'b1);
    for (k = 0; k < 4; k++) send_sample(enc_now + 32'd8, 1'b1);
  endtask

  // Steps near the target are held, except the first after a reversal.
  task automatic test_target_stop();
    wait_idle();
    load_gear_setup(32'h10000, 1, 0, 0, 7, stepper_pos, 1, 1);
    send_sample(enc_now + 32'd2, 1'b1);
    send_sample(enc_now + 32'd2, 1'b1);
    send_sample(enc_now - 32'd4, 1'b1);
    send_sample(enc_now - 32'd2, 1'b1);
    send_sample(enc_now - 32'd2, 1'b1);
  endtask

  task automatic test_extremes();
    wait_idle();
    load_gear_setup(32'hFF_FFFF, 32'hFFFF, 32'hFFFF, 32'hFFFF, 0, 32'h7FFF_FFFF, 1,
                    32'hFFFF);
    send_sample(32'h8000_0000, 1'b1);
    send_sample(32'h7FFF_FFFF, 1'b1);
    send_sample(32'h0000_0000, 1'b1);
    send_sample(32'hFFFF_FFFF, 1'b1);
  endtask

  // Encoder walks with drifting direction and occasional wild jumps.
  task automatic test_random_gearing();
    int          p, k, dsign, delta;
    logic [31:0] spc, cps_i, cps_f, win, bl, tgt, tgt_en, thr, enc;
    logic        en;
    for (p = 0; p < 8; p++) begin
      wait_idle();
      spc   = (p == 1) ? 32'd0 : (p == 2) ? 32'hFF_FFFF : $urandom_range(32'h2000, 32'h40000);
      cps_i = (p == 2) ? 32'hFFFF : (p == 3) ? 32'd0 : $urandom_range(0, 4);
      cps_f = (p == 2) ? 32'hFFFF : (p == 3) ? 32'd0 : $urandom_range(0, 16'hFFFF);
      win   = (p == 4) ? 32'd0 : (p == 5) ? 32'hFFFF : $urandom_range(0, 2500);
      bl    = (p == 0) ? 32'd255 : (p == 6) ? 32'd0 : $urandom_range(0, 255);
      tgt   = stepper_pos + 32'(int'($urandom_range(0, 40)) - 20);
      if (p == 6) tgt = 32'h7FFF_FFFF;
      if (p == 7) tgt = 32'h8000_0000;
      tgt_en = (p == 1) ? 32'd0 : $urandom_range(0, 1);
      thr   = (p == 4) ? 32'd0 : (p == 5) ? 32'hFFFF : $urandom_range(0, 30);
      load_gear_setup(spc, cps_i, cps_f, win, bl, tgt, tgt_en, thr);
      no_idle = (p % 4 == 3);
      dsign = 1;
      for (k = 0; k < 190; k++) begin
        if ($urandom_range(0, 29) == 0) dsign = -dsign;
        if ($urandom_range(0, 99) < 4) begin
          enc = $urandom;
        end else begin
          delta = int'($urandom_range(0, 6));
          delta = dsign * delta + int'($urandom_range(0, 2)) - 1;
          enc = enc_now + 32'(delta);
        end
        en = ($urandom_range(0, 9) != 0);
        send_sample(enc, en);
      end
    end
    no_idle = 1'b0;
  endtask

  initial begin
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_spindle_off();
    test_sync_window();
    test_backward_carry();
    test_target_stop();
    test_extremes();
    test_random_gearing();
    wait_idle();
    if (mismatches == 0 && expected_steps.size() == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
